// File: rtl/vwad_pkg.sv
// ============================================================================
// vwad_pkg
// Shared types, constants and the step size table for the variable width
// ADPCM decoder.
// ============================================================================
package vwad_pkg;

    localparam int STEP_W = 7;   // step index width
    localparam int PRED_W = 12;  // predictor width
    localparam int SIZE_W = 14;  // step size width (max 13899)
    localparam int MAG_W  = 15;  // difference magnitude width
    localparam int SUM_W  = 17;  // predictor plus difference

    localparam logic [STEP_W-1:0]        STEP_MAX     = 7'd79;
    localparam logic [STEP_W-1:0]        NARROW_BELOW = 7'd18;
    localparam logic signed [PRED_W-1:0] PRED_MIN     = 12'sh800;
    localparam logic signed [PRED_W-1:0] PRED_MAX     = 12'sh7FF;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       track_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               last_of_byte;
    } t_out_item;

    typedef struct packed {
        logic [STEP_W-1:0]        step_pos;
        logic signed [PRED_W-1:0] pred;
        logic [3:0]               code;
        logic                     force_narrow;
    } t_alu_req;

    typedef struct packed {
        logic [STEP_W-1:0]        step_pos;
        logic signed [PRED_W-1:0] pred;
        logic                     narrow;
    } t_alu_res;

    function automatic logic [SIZE_W-1:0] step_size(input logic [STEP_W-1:0] idx);
        logic [SIZE_W-1:0] s;
        case (idx)
            7'd0:  s = 14'd7;     7'd1:  s = 14'd8;     7'd2:  s = 14'd9;
            7'd3:  s = 14'd10;    7'd4:  s = 14'd11;    7'd5:  s = 14'd12;
            7'd6:  s = 14'd13;    7'd7:  s = 14'd14;    7'd8:  s = 14'd16;
            7'd9:  s = 14'd17;    7'd10: s = 14'd19;    7'd11: s = 14'd21;
            7'd12: s = 14'd23;    7'd13: s = 14'd25;    7'd14: s = 14'd28;
            7'd15: s = 14'd31;    7'd16: s = 14'd34;    7'd17: s = 14'd37;
            7'd18: s = 14'd41;    7'd19: s = 14'd45;    7'd20: s = 14'd50;
            7'd21: s = 14'd55;    7'd22: s = 14'd60;    7'd23: s = 14'd66;
            7'd24: s = 14'd73;    7'd25: s = 14'd80;    7'd26: s = 14'd88;
            7'd27: s = 14'd97;    7'd28: s = 14'd107;   7'd29: s = 14'd118;
            7'd30: s = 14'd130;   7'd31: s = 14'd143;   7'd32: s = 14'd157;
            7'd33: s = 14'd173;   7'd34: s = 14'd190;   7'd35: s = 14'd209;
            7'd36: s = 14'd230;   7'd37: s = 14'd253;   7'd38: s = 14'd279;
            7'd39: s = 14'd307;   7'd40: s = 14'd337;   7'd41: s = 14'd371;
            7'd42: s = 14'd408;   7'd43: s = 14'd449;   7'd44: s = 14'd494;
            7'd45: s = 14'd544;   7'd46: s = 14'd598;   7'd47: s = 14'd658;
            7'd48: s = 14'd724;   7'd49: s = 14'd796;   7'd50: s = 14'd876;
            7'd51: s = 14'd963;   7'd52: s = 14'd1060;  7'd53: s = 14'd1166;
            7'd54: s = 14'd1282;  7'd55: s = 14'd1411;  7'd56: s = 14'd1552;
            7'd57: s = 14'd1707;  7'd58: s = 14'd1878;  7'd59: s = 14'd2066;
            7'd60: s = 14'd2272;  7'd61: s = 14'd2499;  7'd62: s = 14'd2749;
            7'd63: s = 14'd3024;  7'd64: s = 14'd3327;  7'd65: s = 14'd3660;
            7'd66: s = 14'd4026;  7'd67: s = 14'd4428;  7'd68: s = 14'd4871;
            7'd69: s = 14'd5358;  7'd70: s = 14'd5894;  7'd71: s = 14'd6484;
            7'd72: s = 14'd7132;  7'd73: s = 14'd7845;  7'd74: s = 14'd8630;
            7'd75: s = 14'd9493;  7'd76: s = 14'd10442; 7'd77: s = 14'd11487;
            7'd78: s = 14'd12635;
            default: s = 14'd13899;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/vwad_alu.sv
// ============================================================================
// vwad_alu
// Shared decode unit: one code in, updated step index and predictor out.
// ============================================================================
module vwad_alu import vwad_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [SIZE_W-1:0]        step;
    logic                     narrow;
    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic signed [SUM_W-1:0]  diff;
    logic signed [SUM_W-1:0]  sum;
    logic signed [4:0]        adj;
    logic signed [STEP_W:0]   idx_next;

    always_comb begin
        step   = step_size(i_req.step_pos);
        narrow = (i_req.step_pos < NARROW_BELOW) || i_req.force_narrow;

        // build the magnitude from the step and the code bits
        mag = MAG_W'(step >> 3);
        if (narrow) begin
            if (i_req.code[0]) mag = mag + MAG_W'(step);
            neg = i_req.code[1];
            adj = i_req.code[0] ? 5'sd2 : -5'sd1;
        end else begin
            mag = mag + (i_req.code[0] ? MAG_W'(step >> 2) : '0)
                      + (i_req.code[1] ? MAG_W'(step >> 1) : '0)
                      + (i_req.code[2] ? MAG_W'(step) : '0);
            neg = i_req.code[3];
            adj = i_req.code[2] ? $signed({2'b00, i_req.code[1:0], 1'b0}) + 5'sd2
                                : -5'sd1;
        end

        diff = $signed({2'b00, mag});
        if (neg) diff = -diff;
        sum = SUM_W'(i_req.pred) + diff;

        if (sum < SUM_W'(PRED_MIN)) begin
            o_res.pred = PRED_MIN;
        end else if (sum > SUM_W'(PRED_MAX)) begin
            o_res.pred = PRED_MAX;
        end else begin
            o_res.pred = sum[PRED_W-1:0];
        end

        idx_next = $signed({1'b0, i_req.step_pos}) + (STEP_W+1)'(adj);
        if (idx_next < 0) begin
            o_res.step_pos = '0;
        end else if (idx_next > $signed({1'b0, STEP_MAX})) begin
            o_res.step_pos = STEP_MAX;
        end else begin
            o_res.step_pos = idx_next[STEP_W-1:0];
        end

        o_res.narrow = narrow;
    end

endmodule

// File: rtl/variable_width_adpcm_decoder_unit.sv
// ============================================================================
// variable_width_adpcm_decoder_unit
// Decodes packed 2/4-bit IMA style ADPCM bytes into 16-bit PCM samples.
// ============================================================================
// One code byte is taken per transfer and unpacked from bit 0 upward. Each
// code is 2 bits wide while the step index is below 18 or when only two bits
// of the byte remain, and 4 bits wide otherwise, so a byte yields 2 to 4
// samples; the last one carries last_of_byte. A byte is loaded and then
// decoded at one sample per cycle through a single shared decode unit (step
// table lookup, difference build, predictor add and clamp) while the output
// side does not stall. The input side stalls while a byte is being unpacked.
// An output register holds the latest sample, so the next byte can be taken
// while the final sample of the previous one still waits for its transfer.
// A set track_start resets the predictor to 0 and loads the configured track
// start step index (saturated to 79) before the byte is decoded. Write the
// track start step index only while the block is idle.
// ============================================================================
module variable_width_adpcm_decoder_unit import vwad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_data,
    // code byte input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    // sample output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    t_state                   r_state, n_state;
    logic [STEP_W-1:0]        r_init_idx;
    logic [7:0]               r_bits, n_bits;
    logic [1:0]               r_pairs, n_pairs;   // 2-bit groups already consumed
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [PRED_W-1:0] r_pred, n_pred;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_data, n_out_data;

    logic     in_xfer;
    logic     do_step;
    logic     last;
    logic [2:0] pairs_sum;
    t_alu_req alu_req;
    t_alu_res alu_res;

    // Shared decode unit, used once per sample.
    assign alu_req.step_pos     = r_step;
    assign alu_req.pred         = r_pred;
    assign alu_req.code         = r_bits[3:0];
    assign alu_req.force_narrow = (r_pairs == 2'd3);

    vwad_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign pairs_sum = {1'b0, r_pairs} + (alu_res.narrow ? 3'd1 : 3'd2);
    assign last      = pairs_sum[2];

    // Handshake outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        in_xfer    = (r_state == ST_IDLE) && i_in_valid;
        // advance only when the output register is free or being drained
        do_step    = (r_state == ST_RUN) && (!r_out_valid || !i_out_stall);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (do_step && last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_bits      = r_bits;
        n_pairs     = r_pairs;
        n_step      = r_step;
        n_pred      = r_pred;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;

        if (in_xfer) begin
            n_bits  = i_in_data.code_byte;
            n_pairs = '0;
            if (i_in_data.track_start) begin
                n_pred = '0;
                n_step = (r_init_idx > STEP_MAX) ? STEP_MAX : r_init_idx;
            end
        end

        if (do_step) begin
            n_bits      = alu_res.narrow ? (r_bits >> 2) : (r_bits >> 4);
            n_pairs     = pairs_sum[1:0];
            n_step      = alu_res.step_pos;
            n_pred      = alu_res.pred;
            n_out_valid = 1'b1;
            n_out_data.pcm_sample   = {alu_res.pred, 4'b0000};
            n_out_data.last_of_byte = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init_idx  <= '0;
            r_step      <= '0;
            r_pred      <= '0;
            r_pairs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pred      <= n_pred;
            r_pairs     <= n_pairs;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_init_idx <= i_cfg_data;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_MAX)
        else $error("step index left its range");

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_RUN) && (r_pairs == 2'd0))
        else $error("byte transfer did not start unpacking");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_step && last) |=> (r_state == ST_IDLE) && o_out_valid
                              && o_out_data.last_of_byte)
        else $error("final sample did not end the byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("pending sample overwritten");
`endif

endmodule
